// ===== rtl/pect_pkg.sv =====
// Package for the ear clipping triangulator.
// Holds the default sizes, the queue depth and the result status codes.
package pect_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COORD_WIDTH  = 24;
  localparam int QUEUE_DEPTH      = 4;
  localparam int STATUS_WIDTH     = 3;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_ZERO  = 3'd2,
    ST_NOEAR = 3'd3,
    ST_OVF   = 3'd4
  } status_t;

endpackage

// ===== rtl/polygon_ear_clip_triangulator_core.sv =====
// Ear clipping triangulator top level: load front end, request queue and triangulation back end.
// Throughput: one vertex request per cycle while the four entry queue has room; busy is its full flag.
// After the last vertex, each pass runs ring setup, collinear scan and area, a rescan per collinear
// removal, then tries ears and tests each vertex against each tried ear, roughly cubic in all;
// errors end the first pass, a success reruns to emit.
// Reset (synchronous, rst high) clears the load count, the queue and the back end state; results
// appear for one cycle with result_valid and the receiver cannot stall them.
module polygon_ear_clip_triangulator_core #(
  parameter int MAX_VERTICES = pect_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = pect_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          last_vertex,
  output logic signed [COORD_WIDTH-1:0] ax,
  output logic signed [COORD_WIDTH-1:0] ay,
  output logic signed [COORD_WIDTH-1:0] bx,
  output logic signed [COORD_WIDTH-1:0] by,
  output logic signed [COORD_WIDTH-1:0] cx,
  output logic signed [COORD_WIDTH-1:0] cy,
  output logic [pect_pkg::STATUS_WIDTH-1:0] status,
  output logic                          last_result,
  output logic                          result_valid
);
  import pect_pkg::*;

  localparam int EW = 2 * COORD_WIDTH + $clog2(MAX_VERTICES) + $clog2(MAX_VERTICES + 1) + 3;

  logic          push, pop, full, empty;
  logic [EW-1:0] wdata, rdata;

  assign busy = full;

  pect_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .start(start), .x_coord(x_coord), .y_coord(y_coord),
    .last_vertex(last_vertex), .full(full), .push(push), .wdata(wdata)
  );

  pect_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .pop(pop), .rdata(rdata),
    .full(full), .empty(empty)
  );

  pect_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .rdata(rdata), .pop(pop),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
    .status(status), .last_result(last_result), .result_valid(result_valid)
  );

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> last_result)
    else $error("error result without last_result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> (ax == '0 && ay == '0 && bx == '0 &&
      by == '0 && cx == '0 && cy == '0))
    else $error("error result with nonzero corners");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on consecutive cycles");
endmodule

// ===== rtl/pect_queue.sv =====
// Short request queue between the load front end and the triangulation back end.
// Generic width and depth; no package dependencies.
module pect_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      fill <= fill + CW'(push && !full) - CW'(pop && !empty);
    end
  end
endmodule

// ===== rtl/pect_front.sv =====
// Load front end: drops duplicate and closing vertices, counts the store and flags overflow.
// Pushes store and end requests into the queue; uses no package items.
module pect_front #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          last_vertex,
  input  logic                          full,
  output logic                          push,
  output logic [2*COORD_WIDTH+$clog2(MAX_VERTICES)+$clog2(MAX_VERTICES+1)+2:0] wdata
);
  localparam int CW  = COORD_WIDTH;
  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int CNW = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [IW-1:0]        idx;
    logic [CNW-1:0]       cnt;
    logic                 store;
    logic                 last;
    logic                 ovf;
  } entry_t;

  logic [CNW-1:0]       cnt;
  logic                 ovf;
  logic signed [CW-1:0] prevx, prevy, firstx, firsty;

  logic                 accept, is_dup, has_room, is_close, store, ovf_next, close;
  logic [CNW-1:0]       cnt_next;
  logic signed [CW-1:0] prevx_next, prevy_next, firstx_next, firsty_next;
  entry_t               ent;

  always_comb begin
    accept      = start && !full;
    is_dup      = (cnt != '0) && (x_coord == prevx) && (y_coord == prevy);
    has_room    = (cnt < CNW'(MAX_VERTICES));
    is_close    = last_vertex && (x_coord == firstx) && (y_coord == firsty);
    store       = !ovf && !is_dup && has_room;
    ovf_next    = ovf || (!is_dup && !has_room && !is_close);
    cnt_next    = cnt + CNW'(store);
    prevx_next  = store ? x_coord : prevx;
    prevy_next  = store ? y_coord : prevy;
    firstx_next = (store && cnt == '0) ? x_coord : firstx;
    firsty_next = (store && cnt == '0) ? y_coord : firsty;
    close       = (cnt_next > CNW'(1)) && (prevx_next == firstx_next) &&
                  (prevy_next == firsty_next);
    ent.x       = x_coord;
    ent.y       = y_coord;
    ent.idx     = cnt[IW-1:0];
    ent.cnt     = close ? cnt_next - CNW'(1) : cnt_next;
    ent.store   = store;
    ent.last    = last_vertex;
    ent.ovf     = ovf_next;
    push        = accept && (store || last_vertex);
    wdata       = ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      cnt <= last_vertex ? '0 : cnt_next;
      ovf <= last_vertex ? 1'b0 : ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prevx  <= prevx_next;
      prevy  <= prevy_next;
      firstx <= firstx_next;
      firsty <= firsty_next;
    end
  end
endmodule

// ===== rtl/pect_cross.sv =====
// Three stage exact cross product (b - a) x (c - a) on signed coordinates.
// Registers the differences, then the products, then the result; one new operand set per cycle; no package items.
module pect_cross #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  output logic signed [2*COORD_WIDTH+2:0] cr
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = 2 * COORD_WIDTH + 2;
  localparam int RW = 2 * COORD_WIDTH + 3;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [MW-1:0] m1, m2;

  always_ff @(posedge clk) begin
    d1x <= DW'(bx) - DW'(ax);
    d1y <= DW'(by) - DW'(ay);
    d2x <= DW'(cx) - DW'(ax);
    d2y <= DW'(cy) - DW'(ay);
    m1  <= d1x * d2y;
    m2  <= d1y * d2x;
    cr  <= RW'(m1) - RW'(m2);
  end
endmodule

// ===== rtl/pect_back.sv =====
// Triangulation back end: vertex and ring memories, collinear removal, area sign and ear search.
// Depends on pect_pkg for status codes and on pect_cross for the cross products.
module pect_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  logic [2*COORD_WIDTH+$clog2(MAX_VERTICES)+$clog2(MAX_VERTICES+1)+2:0] rdata,
  output logic pop,
  output logic signed [COORD_WIDTH-1:0] ax,
  output logic signed [COORD_WIDTH-1:0] ay,
  output logic signed [COORD_WIDTH-1:0] bx,
  output logic signed [COORD_WIDTH-1:0] by,
  output logic signed [COORD_WIDTH-1:0] cx,
  output logic signed [COORD_WIDTH-1:0] cy,
  output logic [pect_pkg::STATUS_WIDTH-1:0] status,
  output logic last_result,
  output logic result_valid
);
  import pect_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int CNW = $clog2(MAX_VERTICES + 1);
  localparam int RW  = 2 * CW + 3;
  localparam int AW  = RW + IW + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [IW-1:0]        idx;
    logic [CNW-1:0]       cnt;
    logic                 store;
    logic                 last;
    logic                 ovf;
  } entry_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_RINIT, S_L0, S_L1, S_L2, S_L3, S_CRW, S_CHK, S_ADEC,
    S_W0, S_W1, S_W2, S_W3, S_W4, S_WADV, S_F0, S_F1, S_F2, S_F3
  } state_t;

  typedef enum logic [1:0] {M_COL, M_AREA, M_EAR} mode_t;
  typedef enum logic [2:0] {CS_ABC, CS_ABW, CS_BCW, CS_CAW, CS_ORG} csel_t;

  pt_t     vmem [MAX_VERTICES];
  logic [IW-1:0] nmem [MAX_VERTICES];
  logic [IW-1:0] pmem [MAX_VERTICES];

  pt_t            vrd;
  logic [IW-1:0]  nrd, prd;
  logic [IW-1:0]  vaddr, raddr, naddr, ndata, paddr, pdata;
  logic           vwe, nwe, pwe, unlink;

  state_t         state, ret;
  mode_t          mode;
  csel_t          csel;
  logic [1:0]     wcnt;
  logic [CNW-1:0] rem, t, u, n0;
  logic [IW-1:0]  head, c, pi, qi, w, wn, ri;
  pt_t            p0, p1, p2, pw, ca, cb, cc;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] cr;
  logic           ccw, fpos, ovfl, emit;
  entry_t         ent;

  assign ent = entry_t'(rdata);
  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    unique case (csel)
      CS_ABC: begin ca = p0; cb = p1; cc = p2; end
      CS_ABW: begin ca = p0; cb = p1; cc = pw; end
      CS_BCW: begin ca = p1; cb = p2; cc = pw; end
      CS_CAW: begin ca = p2; cb = p0; cc = pw; end
      CS_ORG: begin ca = '0; cb = p1; cc = p2; end
      default: begin ca = p0; cb = p1; cc = p2; end
    endcase
  end

  pect_cross #(.COORD_WIDTH(CW)) u_cross (
    .clk(clk), .ax(ca.x), .ay(ca.y), .bx(cb.x), .by(cb.y), .cx(cc.x), .cy(cc.y),
    .cr(cr)
  );

  always_comb begin
    unlink = ((state == S_CHK) && (mode == M_COL) && (cr == '0)) ||
             ((state == S_WADV) && ((u + CNW'(1)) == rem));
    case (state)
      S_L1:    vaddr = prd;
      S_L2:    vaddr = qi;
      S_W0:    vaddr = w;
      S_F0:    vaddr = head;
      S_F1:    vaddr = nrd;
      S_F2:    vaddr = nrd;
      default: vaddr = c;
    endcase
    case (state)
      S_W0:    raddr = w;
      S_F0:    raddr = head;
      S_F1:    raddr = nrd;
      default: raddr = c;
    endcase
    vwe = pop && ent.store;
    nwe = (state == S_RINIT) || unlink;
    pwe = nwe;
    if (state == S_RINIT) begin
      naddr = ri;
      ndata = (ri == IW'(rem - CNW'(1))) ? '0 : ri + IW'(1);
      paddr = ri;
      pdata = (ri == '0) ? IW'(rem - CNW'(1)) : ri - IW'(1);
    end else begin
      naddr = pi;
      ndata = qi;
      paddr = qi;
      pdata = pi;
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[ent.idx] <= '{x: ent.x, y: ent.y};
    end
    if (nwe) begin
      nmem[naddr] <= ndata;
    end
    if (pwe) begin
      pmem[paddr] <= pdata;
    end
    vrd <= vmem[vaddr];
    nrd <= nmem[raddr];
    prd <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      last_result  <= 1'b0;
      status       <= ST_OK;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop && ent.last) begin
            ovfl  <= ent.ovf;
            rem   <= ent.cnt;
            n0    <= ent.cnt;
            emit  <= 1'b0;
            state <= S_START;
          end
        end
        S_START: begin
          ri <= '0;
          if (ovfl || rem < CNW'(3)) begin
            {ax, ay, bx, by, cx, cy} <= '0;
            status       <= ovfl ? ST_OVF : ST_FEW;
            last_result  <= 1'b1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_RINIT;
          end
        end
        S_RINIT: begin
          if (ri == IW'(rem - CNW'(1))) begin
            head  <= '0;
            c     <= '0;
            t     <= '0;
            mode  <= M_COL;
            state <= S_L0;
          end else begin
            ri <= ri + IW'(1);
          end
        end
        S_L0: state <= S_L1;
        S_L1: begin
          p1    <= vrd;
          pi    <= prd;
          qi    <= nrd;
          state <= S_L2;
        end
        S_L2: begin
          p0    <= vrd;
          state <= S_L3;
        end
        S_L3: begin
          p2    <= vrd;
          csel  <= (mode == M_AREA) ? CS_ORG : CS_ABC;
          wcnt  <= '0;
          ret   <= S_CHK;
          state <= S_CRW;
        end
        S_CRW: begin
          if (wcnt == 2'd2) begin
            state <= ret;
          end else begin
            wcnt <= wcnt + 2'd1;
          end
        end
        S_CHK: begin
          unique case (mode)
            M_COL: begin
              if (cr == '0) begin
                if (c == head) begin
                  head <= qi;
                  c    <= qi;
                end else begin
                  c <= head;
                end
                rem <= rem - CNW'(1);
                t   <= '0;
                if (rem - CNW'(1) < CNW'(3)) begin
                  {ax, ay, bx, by, cx, cy} <= '0;
                  status       <= ST_FEW;
                  last_result  <= 1'b1;
                  result_valid <= 1'b1;
                  state        <= S_IDLE;
                end else begin
                  state <= S_L0;
                end
              end else if ((t + CNW'(1)) == rem) begin
                mode  <= M_AREA;
                c     <= head;
                t     <= '0;
                acc   <= '0;
                state <= S_L0;
              end else begin
                t     <= t + CNW'(1);
                c     <= qi;
                state <= S_L0;
              end
            end
            M_AREA: begin
              acc <= acc + AW'(cr);
              if ((t + CNW'(1)) == rem) begin
                state <= S_ADEC;
              end else begin
                t     <= t + CNW'(1);
                c     <= qi;
                state <= S_L0;
              end
            end
            default: begin
              if (ccw ? (cr > 0) : (cr < 0)) begin
                w     <= head;
                u     <= '0;
                state <= S_W0;
              end else if ((t + CNW'(1)) == rem) begin
                {ax, ay, bx, by, cx, cy} <= '0;
                status       <= ST_NOEAR;
                last_result  <= 1'b1;
                result_valid <= 1'b1;
                state        <= S_IDLE;
              end else begin
                t     <= t + CNW'(1);
                c     <= qi;
                state <= S_L0;
              end
            end
          endcase
        end
        S_ADEC: begin
          ccw <= ~acc[AW-1];
          if (acc == '0) begin
            {ax, ay, bx, by, cx, cy} <= '0;
            status       <= ST_ZERO;
            last_result  <= 1'b1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (rem > CNW'(3)) begin
            mode  <= M_EAR;
            c     <= head;
            t     <= '0;
            state <= S_L0;
          end else begin
            state <= S_F0;
          end
        end
        S_W0: state <= S_W1;
        S_W1: begin
          pw <= vrd;
          wn <= nrd;
          if (w == pi || w == c || w == qi) begin
            state <= S_WADV;
          end else begin
            csel  <= CS_ABW;
            wcnt  <= '0;
            ret   <= S_W2;
            state <= S_CRW;
          end
        end
        S_W2: begin
          fpos <= ~cr[RW-1];
          if (cr == '0) begin
            state <= S_WADV;
          end else begin
            csel  <= CS_BCW;
            wcnt  <= '0;
            ret   <= S_W3;
            state <= S_CRW;
          end
        end
        S_W3: begin
          if (cr == '0 || (~cr[RW-1]) != fpos) begin
            state <= S_WADV;
          end else begin
            csel  <= CS_CAW;
            wcnt  <= '0;
            ret   <= S_W4;
            state <= S_CRW;
          end
        end
        S_W4: begin
          if (cr == '0 || (~cr[RW-1]) != fpos) begin
            state <= S_WADV;
          end else if ((t + CNW'(1)) == rem) begin
            {ax, ay, bx, by, cx, cy} <= '0;
            status       <= ST_NOEAR;
            last_result  <= 1'b1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            t     <= t + CNW'(1);
            c     <= qi;
            state <= S_L0;
          end
        end
        S_WADV: begin
          if ((u + CNW'(1)) == rem) begin
            ax           <= p0.x;
            ay           <= p0.y;
            bx           <= p1.x;
            by           <= p1.y;
            cx           <= p2.x;
            cy           <= p2.y;
            status       <= ST_OK;
            last_result  <= 1'b0;
            result_valid <= emit;
            if (c == head) begin
              head <= qi;
              c    <= qi;
            end else begin
              c <= head;
            end
            rem <= rem - CNW'(1);
            t   <= '0;
            state <= (rem - CNW'(1) > CNW'(3)) ? S_L0 : S_F0;
          end else begin
            u     <= u + CNW'(1);
            w     <= wn;
            state <= S_W0;
          end
        end
        S_F0: state <= S_F1;
        S_F1: begin
          p0    <= vrd;
          state <= S_F2;
        end
        S_F2: begin
          p1    <= vrd;
          state <= S_F3;
        end
        S_F3: begin
          if (emit) begin
            ax           <= p0.x;
            ay           <= p0.y;
            bx           <= p1.x;
            by           <= p1.y;
            cx           <= vrd.x;
            cy           <= vrd.y;
            status       <= ST_OK;
            last_result  <= 1'b1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            emit  <= 1'b1;
            rem   <= n0;
            ri    <= '0;
            state <= S_RINIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
